// ===== rtl/tsgr_pkg.sv =====
// Shared types, codes and the SGR attribute function for the terminal engine.
package tsgr_pkg;

  // Default geometry and parser limit.
  localparam int SCREEN_ROWS_DEF   = 25;
  localparam int SCREEN_COLS_DEF   = 80;
  localparam int MAX_SGR_CODES_DEF = 10;

  // Item command codes.
  localparam logic [2:0] MODE_WRITE  = 3'd0;
  localparam logic [2:0] MODE_READ   = 3'd1;
  localparam logic [2:0] MODE_PROMPT = 3'd2;
  localparam logic [2:0] MODE_CLEAR  = 3'd3;
  localparam logic [2:0] MODE_ATTR   = 3'd4;

  // Character codes.
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_M      = 8'h6D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [9:0] ACCUM_MAX = 10'd1023;

  // Escape parser phase.
  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESC,
    PH_CSI,
    PH_SWALLOW
  } phase_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SCR_RD,
    S_SCR_WR,
    S_FILL,
    S_CLEAR,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic scr_rd;
    logic scr_wr;
    logic sweep;
    logic cnt_clr;
    logic cnt_inc;
    logic load_out;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scroll;
    logic is_clear;
    logic cnt_last;
    logic copy_last;
  } ctl_sts_t;

  // Apply one SGR code to an attribute; unknown codes leave it unchanged.
  function automatic logic [7:0] sgr_apply(input logic [7:0] attr, input logic [9:0] code);
    logic [3:0] fg;
    logic [3:0] bg;
    fg = attr[3:0];
    bg = attr[7:4];
    if (code == 10'd0) begin
      fg = 4'd7;
      bg = 4'd0;
    end else if (code >= 10'd30 && code <= 10'd37) begin
      fg = 4'(code - 10'd30);
    end else if (code >= 10'd90 && code <= 10'd97) begin
      fg = 4'(code - 10'd90 + 10'd8);
    end else if (code >= 10'd40 && code <= 10'd47) begin
      bg = 4'(code - 10'd40);
    end else if (code >= 10'd100 && code <= 10'd107) begin
      bg = 4'(code - 10'd100 + 10'd8);
    end
    return {bg, fg};
  endfunction

endpackage

// ===== rtl/tsgr_ctrl.sv =====
// Sequencing state machine for the terminal engine: item flow, sweeps and result handshake.
module tsgr_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tsgr_pkg::ctl_sts_t sts_i,
  output tsgr_pkg::ctl_cmd_t cmd_o
);
  import tsgr_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and result-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep   = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.exec    = 1'b1;
        cmd_o.cnt_clr = 1'b1;
        if (sts_i.need_scroll) begin
          state_d = S_SCR_RD;
        end else if (sts_i.is_clear) begin
          state_d = S_CLEAR;
        end else begin
          state_d = S_DONE;
        end
      end
      S_SCR_RD: begin
        cmd_o.scr_rd = 1'b1;
        state_d      = S_SCR_WR;
      end
      S_SCR_WR: begin
        cmd_o.scr_wr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        state_d       = sts_i.copy_last ? S_FILL : S_SCR_RD;
      end
      S_FILL, S_CLEAR: begin
        cmd_o.sweep   = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.cnt_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // A new result only appears on the way out of the finishing state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result raised outside the finishing state");

  // No item is taken while a sweep is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCR_RD || state_q == S_SCR_WR || state_q == S_FILL ||
     state_q == S_CLEAR || state_q == S_INIT) |-> !in_ready_o)
    else $error("input ready during a sweep");

endmodule

// ===== rtl/tsgr_dp.sv =====
// Datapath for the terminal engine: screen store, cursor, attribute and SGR parser.
module tsgr_dp #(
  parameter int SCREEN_ROWS   = tsgr_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS   = tsgr_pkg::SCREEN_COLS_DEF,
  parameter int MAX_SGR_CODES = tsgr_pkg::MAX_SGR_CODES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tsgr_pkg::ctl_cmd_t cmd_i,
  output tsgr_pkg::ctl_sts_t sts_o,
  input  logic [2:0]         mode_i,
  input  logic [7:0]         data_byte_i,
  input  logic               end_of_string_i,
  input  logic [4:0]         read_row_i,
  input  logic [6:0]         read_col_i,
  output logic [7:0]         cell_char_o,
  output logic [7:0]         cell_attr_o,
  output logic [4:0]         cursor_row_now_o,
  output logic [6:0]         cursor_col_now_o,
  output logic [7:0]         attr_now_o,
  output logic               in_escape_o
);
  import tsgr_pkg::*;

  localparam int CELLS       = SCREEN_ROWS * SCREEN_COLS;
  localparam int COPY_CELLS  = (SCREEN_ROWS - 1) * SCREEN_COLS;
  localparam int AW          = $clog2(CELLS);
  localparam int RW          = $clog2(SCREEN_ROWS + 1);
  localparam int CW          = $clog2(SCREEN_COLS + 1);

  // Screen store.
  logic [15:0] mem [CELLS];
  logic [15:0] rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [15:0]   wr_data;
  logic          wr_en;

  // Latched item.
  logic [2:0] mode_q;
  logic [7:0] data_q;
  logic       eos_q;
  logic [4:0] rr_q;
  logic [6:0] rc_q;
  logic       rd_ok_q;

  // Terminal state.
  logic [RW-1:0] row_q, row_d, prow_q, prow_d;
  logic [CW-1:0] col_q, col_d, pcol_q, pcol_d;
  logic [7:0]    attr_q, attr_d;
  phase_e        phase_q, phase_d;
  logic [9:0]    accum_q, accum_d;
  logic          digits_q, digits_d;
  logic [3:0]    codes_q, codes_d;
  logic [AW-1:0] cnt_q;

  // Step logic.
  logic          put_en, apply_en, cell_we, scroll;
  logic [9:0]    apply_val;
  logic [13:0]   acc_sum;
  logic [RW-1:0] cell_row;
  logic [CW-1:0] cell_col;
  logic [7:0]    cell_ch;
  logic          rd_ok;

  // Result registers.
  logic [7:0] cell_char_q, cell_attr_q, attr_out_q;
  logic [4:0] row_out_q;
  logic [6:0] col_out_q;
  logic       esc_out_q;

  assign rd_ok = (32'(read_row_i) < SCREEN_ROWS) && (32'(read_col_i) < SCREEN_COLS);

  // Item capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      mode_q  <= mode_i;
      data_q  <= data_byte_i;
      eos_q   <= end_of_string_i;
      rr_q    <= read_row_i;
      rc_q    <= read_col_i;
      rd_ok_q <= rd_ok;
    end
  end

  // Parser, attribute and cursor update for one item.
  always_comb begin
    phase_d   = phase_q;
    accum_d   = accum_q;
    digits_d  = digits_q;
    codes_d   = codes_q;
    attr_d    = attr_q;
    row_d     = row_q;
    col_d     = col_q;
    prow_d    = prow_q;
    pcol_d    = pcol_q;
    put_en    = 1'b0;
    apply_en  = 1'b0;
    apply_val = accum_q;
    cell_we   = 1'b0;
    cell_row  = row_q;
    cell_col  = col_q;
    cell_ch   = data_q;
    scroll    = 1'b0;
    acc_sum   = 14'(accum_q) * 14'd10 + 14'(data_q[3:0]);

    case (mode_q)
      MODE_WRITE: begin
        unique case (phase_q)
          PH_TEXT: begin
            if (data_q == CH_ESC) begin
              phase_d = PH_ESC;
            end else begin
              put_en = 1'b1;
            end
          end
          PH_ESC: begin
            if (data_q == CH_LBRACK) begin
              phase_d  = PH_CSI;
              accum_d  = '0;
              digits_d = 1'b0;
              codes_d  = '0;
            end else if (data_q != CH_ESC) begin
              phase_d = PH_TEXT;
              put_en  = 1'b1;
            end
          end
          PH_CSI: begin
            if (data_q == CH_M) begin
              apply_en = digits_q;
              phase_d  = PH_TEXT;
            end else if (data_q >= CH_ZERO && data_q <= CH_NINE) begin
              accum_d  = (acc_sum > 14'(ACCUM_MAX)) ? ACCUM_MAX : acc_sum[9:0];
              digits_d = 1'b1;
            end else if (data_q == CH_SEMI && digits_q) begin
              apply_en = 1'b1;
              accum_d  = '0;
              digits_d = 1'b0;
              codes_d  = codes_q + 4'd1;
              if (codes_d >= 4'(MAX_SGR_CODES)) begin
                phase_d = PH_SWALLOW;
              end
            end
          end
          default: begin
            phase_d = PH_TEXT;
          end
        endcase
        // End of string closes the sequence and applies a pending code.
        if (eos_q) begin
          if (phase_d == PH_CSI && digits_d) begin
            apply_en  = 1'b1;
            apply_val = accum_d;
          end
          phase_d  = PH_TEXT;
          accum_d  = '0;
          digits_d = 1'b0;
          codes_d  = '0;
        end
        if (apply_en) begin
          attr_d = sgr_apply(attr_q, apply_val);
        end
        // Character placement and cursor motion.
        if (put_en) begin
          if (data_q == CH_LF) begin
            col_d = '0;
            row_d = row_q + RW'(1);
          end else if (data_q == CH_BS) begin
            if (row_q > prow_q || (row_q == prow_q && col_q > pcol_q)) begin
              cell_ch = CH_SPACE;
              if (col_q != '0) begin
                col_d    = col_q - CW'(1);
                cell_col = col_q - CW'(1);
                cell_we  = 1'b1;
              end else if (row_q != '0) begin
                row_d    = row_q - RW'(1);
                col_d    = CW'(SCREEN_COLS - 1);
                cell_row = row_q - RW'(1);
                cell_col = CW'(SCREEN_COLS - 1);
                cell_we  = 1'b1;
              end
            end
          end else begin
            cell_we = 1'b1;
            if (32'(col_q) + 1 == SCREEN_COLS) begin
              col_d = '0;
              row_d = row_q + RW'(1);
            end else begin
              col_d = col_q + CW'(1);
            end
          end
          if (32'(row_d) == SCREEN_ROWS) begin
            row_d  = RW'(SCREEN_ROWS - 1);
            scroll = 1'b1;
          end
        end
      end
      MODE_PROMPT: begin
        prow_d = row_q;
        pcol_d = col_q;
      end
      MODE_CLEAR: begin
        row_d  = '0;
        col_d  = '0;
        prow_d = '0;
        pcol_d = '0;
      end
      MODE_ATTR: begin
        attr_d = data_q;
      end
      default: begin
      end
    endcase
  end

  // Terminal state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q    <= '0;
      col_q    <= '0;
      prow_q   <= '0;
      pcol_q   <= '0;
      attr_q   <= 8'h07;
      phase_q  <= PH_TEXT;
      accum_q  <= '0;
      digits_q <= 1'b0;
      codes_q  <= '0;
    end else if (cmd_i.exec) begin
      row_q    <= row_d;
      col_q    <= col_d;
      prow_q   <= prow_d;
      pcol_q   <= pcol_d;
      attr_q   <= attr_d;
      phase_q  <= phase_d;
      accum_q  <= accum_d;
      digits_q <= digits_d;
      codes_q  <= codes_d;
    end
  end

  // Sweep counter for reset fill, clear and scroll.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + AW'(1);
    end
  end

  assign sts_o.need_scroll = scroll;
  assign sts_o.is_clear    = (mode_q == MODE_CLEAR);
  assign sts_o.cnt_last    = (32'(cnt_q) == CELLS - 1);
  assign sts_o.copy_last   = (32'(cnt_q) == COPY_CELLS - 1);

  // Store port selection.
  always_comb begin
    if (cmd_i.scr_rd) begin
      rd_addr = AW'(32'(cnt_q) + SCREEN_COLS);
    end else if (rd_ok_q) begin
      rd_addr = AW'(32'(rr_q) * SCREEN_COLS + 32'(rc_q));
    end else begin
      rd_addr = '0;
    end
    if (cmd_i.exec) begin
      wr_en   = cell_we;
      wr_addr = AW'(32'(cell_row) * SCREEN_COLS + 32'(cell_col));
      wr_data = {attr_q, cell_ch};
    end else if (cmd_i.scr_wr) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q;
      wr_data = rd_q;
    end else begin
      wr_en   = cmd_i.sweep;
      wr_addr = cnt_q;
      wr_data = {attr_q, CH_SPACE};
    end
  end

  // Screen store write and registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.exec || cmd_i.scr_rd) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (mode_q == MODE_READ && rd_ok_q) begin
        cell_char_q <= rd_q[7:0];
        cell_attr_q <= rd_q[15:8];
      end else begin
        cell_char_q <= '0;
        cell_attr_q <= '0;
      end
      row_out_q  <= 5'(32'(row_q));
      col_out_q  <= 7'(32'(col_q));
      attr_out_q <= attr_q;
      esc_out_q  <= (phase_q != PH_TEXT);
    end
  end

  assign cell_char_o      = cell_char_q;
  assign cell_attr_o      = cell_attr_q;
  assign cursor_row_now_o = row_out_q;
  assign cursor_col_now_o = col_out_q;
  assign attr_now_o       = attr_out_q;
  assign in_escape_o      = esc_out_q;

  // The cursor always sits on the screen between items.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(row_q) < SCREEN_ROWS) && (32'(col_q) < SCREEN_COLS))
    else $error("cursor off screen");

  // Inside a sequence the code count stays below its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CSI) |-> (32'(codes_q) < MAX_SGR_CODES))
    else $error("code count past limit in sequence");

  // The store is never written by two sources in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_i.exec, cmd_i.scr_wr, cmd_i.sweep}))
    else $error("conflicting store writes");

endmodule

// ===== rtl/text_terminal_sgr_engine.sv =====
// Top level: text terminal with ANSI SGR attribute parsing over a cell screen store.
// An item's result is registered after the item is executed; a clear sweeps every cell,
// and a scroll copies each row up one and blanks the last row, both through the
// store's single write port. One item is in work at a time; a result may wait while
// the next item is taken. After reset a fill pass writes the screen before the first
// item is taken.
module text_terminal_sgr_engine #(
  parameter int SCREEN_ROWS   = tsgr_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS   = tsgr_pkg::SCREEN_COLS_DEF,
  parameter int MAX_SGR_CODES = tsgr_pkg::MAX_SGR_CODES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] mode_i,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_string_i,
  input  logic [4:0] read_row_i,
  input  logic [6:0] read_col_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] cell_char_o,
  output logic [7:0] cell_attr_o,
  output logic [4:0] cursor_row_now_o,
  output logic [6:0] cursor_col_now_o,
  output logic [7:0] attr_now_o,
  output logic       in_escape_o
);
  import tsgr_pkg::*;

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  // Sequencer.
  tsgr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Screen store and terminal state.
  tsgr_dp #(
    .SCREEN_ROWS   (SCREEN_ROWS),
    .SCREEN_COLS   (SCREEN_COLS),
    .MAX_SGR_CODES (MAX_SGR_CODES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (mode_i),
    .data_byte_i      (data_byte_i),
    .end_of_string_i  (end_of_string_i),
    .read_row_i       (read_row_i),
    .read_col_i       (read_col_i),
    .cell_char_o      (cell_char_o),
    .cell_attr_o      (cell_attr_o),
    .cursor_row_now_o (cursor_row_now_o),
    .cursor_col_now_o (cursor_col_now_o),
    .attr_now_o       (attr_now_o),
    .in_escape_o      (in_escape_o)
  );

endmodule

// ===== sim/text_terminal_sgr_engine_test.sv =====
// Testbench for the text terminal SGR engine: directed table, then random command traffic.
`timescale 1ns / 100ps

module text_terminal_sgr_engine_test;
  import tsgr_pkg::*;

  localparam int ROWS = SCREEN_ROWS_DEF;
  localparam int COLS = SCREEN_COLS_DEF;
  localparam int MAXC = MAX_SGR_CODES_DEF;
  localparam int CELLS = ROWS * COLS;
  localparam int DOG_LIMIT = 40 * CELLS + 20000;

  // One command item and one result item.
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data;
    logic       eos;
    logic [4:0] row;
    logic [6:0] col;
  } cmd_t;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] at;
    logic [4:0] crow;
    logic [6:0] ccol;
    logic [7:0] attr;
    logic       esc;
  } res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [2:0] mode_i = '0;
  logic [7:0] data_byte_i = '0;
  logic end_of_string_i = 1'b0;
  logic [4:0] read_row_i = '0;
  logic [6:0] read_col_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [7:0] cell_char_o, cell_attr_o, attr_now_o;
  logic [4:0] cursor_row_now_o;
  logic [6:0] cursor_col_now_o;
  logic in_escape_o;

  text_terminal_sgr_engine DUT (.*);

  always #5 clk_i = ~clk_i;

  // Terminal state mirror.
  logic [15:0] scr [CELLS];
  int unsigned crow, ccol, prow, pcol, acc, ntaken;
  logic [7:0] dattr;
  phase_e phase;
  logic digits;

  res_t expected_results[$];
  res_t fixed_results[$];   // typed-in value, or zero when predictor decides
  logic has_fixed[$];
  int errors = 0;
  bit stim_done = 0;
  bit quiet = 0;
  bit hold_off = 0;
  int dog = 0;

  function automatic logic [7:0] sgr_code(logic [7:0] a, int unsigned code);
    logic [3:0] fg, bg;
    fg = a[3:0];
    bg = a[7:4];
    if (code == 0) begin
      fg = 7;
      bg = 0;
    end else if (code >= 30 && code <= 37) fg = code - 30;
    else if (code >= 90 && code <= 97) fg = code - 82;
    else if (code >= 40 && code <= 47) bg = code - 40;
    else if (code >= 100 && code <= 107) bg = code - 92;
    return {bg, fg};
  endfunction

  function automatic void mirror_reset();
    foreach (scr[i]) scr[i] = 16'h0720;
    crow = 0; ccol = 0; prow = 0; pcol = 0;
    dattr = 8'h07; phase = PH_TEXT; acc = 0; digits = 0; ntaken = 0;
  endfunction

  function automatic void put_cell(int unsigned r, int unsigned c, logic [7:0] ch);
    if (r < ROWS && c < COLS) scr[r * COLS + c] = {dattr, ch};
  endfunction

  function automatic void draw_char(logic [7:0] ch);
    if (crow >= ROWS) crow = ROWS - 1;
    if (ccol >= COLS) ccol = 0;
    if (ch == CH_LF) begin
      ccol = 0;
      crow++;
    end else if (ch == CH_BS) begin
      // Backspace never erases into the prompt.
      if (crow > prow || (crow == prow && ccol > pcol)) begin
        if (ccol > 0) begin
          ccol--;
          put_cell(crow, ccol, CH_SPACE);
        end else if (crow > 0) begin
          crow--;
          ccol = COLS - 1;
          put_cell(crow, ccol, CH_SPACE);
        end
      end
    end else begin
      put_cell(crow, ccol, ch);
      if (++ccol == COLS) begin
        ccol = 0;
        crow++;
      end
    end
    if (crow == ROWS) begin
      crow = ROWS - 1;
      for (int i = 0; i < CELLS - COLS; i++) scr[i] = scr[i + COLS];
      for (int c = 0; c < COLS; c++) put_cell(ROWS - 1, c, CH_SPACE);
    end
  endfunction

  function automatic void feed_byte(logic [7:0] b, logic last);
    int unsigned v;
    case (phase)
      PH_TEXT: if (b == CH_ESC) phase = PH_ESC; else draw_char(b);
      PH_ESC: begin
        if (b == CH_LBRACK) begin
          phase = PH_CSI; acc = 0; digits = 0; ntaken = 0;
        end else if (b != CH_ESC) begin
          phase = PH_TEXT;
          draw_char(b);
        end
      end
      PH_CSI: begin
        if (b == CH_M) begin
          if (digits) dattr = sgr_code(dattr, acc);
          phase = PH_TEXT;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          v = acc * 10 + (b - CH_ZERO);
          acc = (v > ACCUM_MAX) ? ACCUM_MAX : v;
          digits = 1;
        end else if (b == CH_SEMI && digits) begin
          dattr = sgr_code(dattr, acc);
          acc = 0; digits = 0;
          ntaken = (ntaken + 1) & 4'hF;
          if (ntaken >= MAXC) phase = PH_SWALLOW;
        end
      end
      default: phase = PH_TEXT;
    endcase
    if (last) begin
      if (phase == PH_CSI && digits) dattr = sgr_code(dattr, acc);
      phase = PH_TEXT; acc = 0; digits = 0; ntaken = 0;
    end
  endfunction

  function automatic res_t predict_terminal(cmd_t c);
    res_t r;
    r = '0;
    case (c.mode)
      MODE_WRITE: feed_byte(c.data, c.eos);
      MODE_READ: if (c.row < ROWS && c.col < COLS) {r.at, r.ch} = scr[c.row * COLS + c.col];
      MODE_PROMPT: begin
        prow = crow; pcol = ccol;
      end
      MODE_CLEAR: begin
        crow = 0; ccol = 0; prow = 0; pcol = 0;
        foreach (scr[i]) scr[i] = {dattr, CH_SPACE};
      end
      MODE_ATTR: dattr = c.data;
      default: ;
    endcase
    r.crow = crow; r.ccol = ccol; r.attr = dattr; r.esc = (phase != PH_TEXT);
    return r;
  endfunction

  // Sender side: valid stays high from one transfer to the next unless an idle gap is taken.
  task automatic send_cmd(cmd_t c, bit typed, res_t fixed);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= c.mode; data_byte_i <= c.data; end_of_string_i <= c.eos;
    read_row_i <= c.row; read_col_i <= c.col;
    expected_results.push_back(predict_terminal(c));
    has_fixed.push_back(typed);
    fixed_results.push_back(fixed);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic cmd_t mk(logic [2:0] m, logic [7:0] d, logic e = 0,
                              logic [4:0] r = 0, logic [6:0] c = 0);
    cmd_t x;
    x.mode = m; x.data = d; x.eos = e; x.row = r; x.col = c;
    return x;
  endfunction

  function automatic cmd_t rnd_byte(logic [7:0] b, int eos_pct = 3);
    return mk(MODE_WRITE, b, $urandom_range(0, 99) < eos_pct, $urandom, $urandom);
  endfunction

  // Random SGR sequence, sometimes broken or too long.
  task automatic send_sgr();
    int n;
    int unsigned code;
    string s;
    n = $urandom_range(0, 12);
    send_cmd(rnd_byte(CH_ESC, 0), 0, '0);
    if ($urandom_range(0, 7) == 0) send_cmd(rnd_byte(CH_ESC, 0), 0, '0);
    send_cmd(rnd_byte(CH_LBRACK, 0), 0, '0);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: code = $urandom_range(30, 37);
        1: code = $urandom_range(40, 47);
        2: code = $urandom_range(90, 97);
        3: code = $urandom_range(100, 107);
        4: code = 0;
        default: code = $urandom_range(0, 99999);
      endcase
      s = $sformatf("%0d", code);
      for (int k = 0; k < s.len(); k++) send_cmd(rnd_byte(s[k], 2), 0, '0);
      if ($urandom_range(0, 15) == 0) send_cmd(rnd_byte($urandom, 0), 0, '0);
      if (i != n - 1) send_cmd(rnd_byte(CH_SEMI, 1), 0, '0);
    end
    if ($urandom_range(0, 5) != 0) send_cmd(rnd_byte(CH_M, 0), 0, '0);
    else send_cmd(rnd_byte(CH_ESC, 100), 0, '0);
  endtask

  task automatic random_item();
    logic [7:0] b;
    case ($urandom_range(0, 19))
      0, 1: send_sgr();
      2, 3: send_cmd(mk(MODE_READ, $urandom, $urandom,
                        $urandom_range(0, 31), $urandom_range(0, 127)), 0, '0);
      4, 5, 6: send_cmd(mk(MODE_READ, $urandom, $urandom, crow, $urandom_range(0, COLS - 1)),
                        0, '0);
      7: send_cmd(mk(MODE_PROMPT, $urandom, $urandom, $urandom, $urandom), 0, '0);
      8: if ($urandom_range(0, 9) == 0)
           send_cmd(mk(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom), 0, '0);
      9: send_cmd(mk(MODE_ATTR, $urandom, $urandom, $urandom, $urandom), 0, '0);
      10: send_cmd(mk($urandom_range(5, 7), $urandom, $urandom, $urandom, $urandom), 0, '0);
      11: send_cmd(rnd_byte(CH_LF), 0, '0);
      12: send_cmd(rnd_byte(CH_BS), 0, '0);
      13: send_cmd(rnd_byte($urandom, 20), 0, '0);
      default: begin
        b = $urandom_range(32, 126);
        send_cmd(rnd_byte(b), 0, '0);
      end
    endcase
  endtask

  // Directed table; fixed value applies where typed is set.
  typedef struct {
    cmd_t c;
    bit   typed;
    res_t r;
  } row_t;

  row_t dir_tab[] = '{
    '{'{MODE_READ, 8'h00, 1'b0, 5'd0, 7'd0}, 1, '{8'h20, 8'h07, 5'd0, 7'd0, 8'h07, 1'b0}},
    '{'{MODE_READ, 8'hFF, 1'b1, 5'd24, 7'd79}, 1, '{8'h20, 8'h07, 5'd0, 7'd0, 8'h07, 1'b0}},
    '{'{MODE_READ, 8'h00, 1'b0, 5'd31, 7'd127}, 1, '{8'h00, 8'h00, 5'd0, 7'd0, 8'h07, 1'b0}},
    '{'{MODE_READ, 8'h00, 1'b0, 5'd25, 7'd0}, 1, '{8'h00, 8'h00, 5'd0, 7'd0, 8'h07, 1'b0}},
    '{'{MODE_READ, 8'h00, 1'b0, 5'd0, 7'd80}, 1, '{8'h00, 8'h00, 5'd0, 7'd0, 8'h07, 1'b0}},
    '{'{MODE_WRITE, 8'h08, 1'b0, 5'd0, 7'd0}, 1, '{8'h00, 8'h00, 5'd0, 7'd0, 8'h07, 1'b0}},
    '{'{MODE_WRITE, 8'hFF, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_WRITE, 8'h1B, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_WRITE, 8'h1B, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_WRITE, 8'h41, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_WRITE, 8'h1B, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_WRITE, 8'h5B, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_WRITE, 8'h39, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_WRITE, 8'h37, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_WRITE, 8'h3B, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_WRITE, 8'h3B, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_WRITE, 8'h34, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_WRITE, 8'h78, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_WRITE, 8'h31, 1'b1, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_PROMPT, 8'h00, 1'b1, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_WRITE, 8'h08, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_WRITE, 8'h0A, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_ATTR, 8'hFF, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{3'd7, 8'h00, 1'b0, 5'd0, 7'd0}, 0, '0},
    '{'{MODE_CLEAR, 8'h00, 1'b0, 5'd0, 7'd0}, 1, '{8'h00, 8'h00, 5'd0, 7'd0, 8'hFF, 1'b0}}
  };

  // Receiver side: random stalls plus one long hold-off.
  initial begin
    int n;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 14);
        repeat (n) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Result checking.
  always @(posedge clk_i) begin
    res_t got, want;
    bit typed;
    res_t fx;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{cell_char_o, cell_attr_o, cursor_row_now_o, cursor_col_now_o, attr_now_o,
              in_escape_o};
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %h", got);
      end else begin
        want = expected_results.pop_front();
        typed = has_fixed.pop_front();
        fx = fixed_results.pop_front();
        if (typed && fx != want) begin
          errors++;
          if (errors <= 10) $display("Table value %h differs from prediction %h", fx, want);
        end
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected ch %h at %h row %0d col %0d attr %h esc %b; got ch %h at %h row %0d col %0d attr %h esc %b",
                     want.ch, want.at, want.crow, want.ccol, want.attr, want.esc,
                     got.ch, got.at, got.crow, got.ccol, got.attr, got.esc);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) dog <= 0;
    else dog <= dog + 1;
    if (dog >= DOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    mirror_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (dir_tab[i]) send_cmd(dir_tab[i].c, dir_tab[i].typed, dir_tab[i].r);
    // Long output stall while commands keep coming.
    hold_off = 1;
    for (int i = 0; i < 30; i++) send_cmd(rnd_byte($urandom_range(32, 126), 0), 0, '0);
    for (int i = 0; i < 160; i++) random_item();
    quiet = 1;
    for (int i = 0; i < 40; i++) random_item();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (2 * CELLS + 50) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
